/* rtl/tals_pkg.sv */
// shared widths and types for the trajectory arc length segmenter
package tals_pkg;

    localparam int COORD_W = 24;                  // coordinate width
    localparam int SOS_W   = 2 * COORD_W + 2;     // sum of three squares
    localparam int ROOT_W  = SOS_W / 2;           // floor square root width
    localparam int REM_W   = ROOT_W + 2;          // root remainder width
    localparam int ARC_W   = 32;                  // arc length width
    localparam int IDX_W   = 16;                  // point index width
    localparam int SQ_CNT_W   = $clog2(COORD_W + 1);
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    localparam logic [IDX_W-1:0] INDEX_LIMIT = {IDX_W{1'b1}};
    localparam logic [ARC_W-1:0] ARC_MAX     = {ARC_W{1'b1}};
    localparam logic [ARC_W-1:0] SEG_LEN_RESET = 32'd1024;

    localparam logic REG_SEGMENT_LENGTH = 1'b0;   // word index from paddr[2]

    typedef logic [COORD_W-1:0] mag_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SQUARE = 4'b0010,
        ST_ROOT   = 4'b0100,
        ST_COMMIT = 4'b1000
    } tals_state_t;

endpackage

/* rtl/trajectory_arc_length_segmenter_unit.sv */
// top level of the trajectory arc length segmenter
// Takes one trajectory point per transaction on the s_ stream (x, y, z in
// 1/1024 cm, tlast marking the final point) and adds the floor length of
// each step to a running arc. A segment transaction leaves on the m_ stream
// when the arc reaches segment_length (tuser 0) or, with a nonzero leftover,
// at the trajectory end (tuser 1); the leading breakpoint at index 0 is not
// sent. The first point of a trajectory is only stored. Every later point is
// accepted, then its three coordinate steps are squared and added one
// multiplier bit per cycle, handed to the bit-serial root (one root bit per
// cycle), handed on once more, and used to update the arc and load the
// result; no new point is accepted before that. A result still waiting on
// m_tready holds the update step. Arc and index saturate.
module trajectory_arc_length_segmenter_unit import tals_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input point stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,    // point_x[23:0], point_y[47:24], point_z[71:48]
    input  logic        s_tlast,    // last_point
    // segment stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // end_index[15:0], segment_arc[47:16]
    output logic        m_tuser,    // final_segment
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tals_state_t          state_reg, state_next;

    logic [ARC_W-1:0]     seg_len_reg;
    logic [COORD_W-1:0]   prev_x_reg, prev_y_reg, prev_z_reg;
    logic [ARC_W-1:0]     arc_reg;
    logic [IDX_W-1:0]     count_reg;
    logic                 have_prev_reg;
    logic                 last_reg;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic [ARC_W-1:0]     out_arc_reg;
    logic                 out_final_reg;

    logic [COORD_W-1:0]   pt_x, pt_y, pt_z;
    logic                 in_fire;
    logic                 cfg_write;
    logic                 sos_start;
    logic                 sos_done;
    logic [SOS_W-1:0]     sos_sum;
    logic                 root_done;
    logic [ROOT_W-1:0]    step_len;
    logic                 out_free;
    logic                 commit;

    logic [ARC_W:0]       arc_sum;
    logic [ARC_W-1:0]     arc_sat;
    logic [IDX_W-1:0]     count_inc;
    logic                 hit;
    logic                 leftover;

    // absolute difference of two signed coordinates
    function automatic mag_t abs_diff(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    assign pt_x = s_tdata[COORD_W-1:0];
    assign pt_y = s_tdata[2*COORD_W-1:COORD_W];
    assign pt_z = s_tdata[3*COORD_W-1:2*COORD_W];

    // configuration port, word index taken from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_SEGMENT_LENGTH);
    assign prdata    = (paddr[2] == REG_SEGMENT_LENGTH) ? seg_len_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_len_reg <= SEG_LEN_RESET;
        end else if (cfg_write) begin
            seg_len_reg <= pwdata;
        end
    end

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign sos_start = in_fire && have_prev_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign commit    = (state_reg == ST_COMMIT) && out_free;

    tals_sos u_sos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sos_start),
        .dx      (abs_diff(pt_x, prev_x_reg)),
        .dy      (abs_diff(pt_y, prev_y_reg)),
        .dz      (abs_diff(pt_z, prev_z_reg)),
        .done    (sos_done),
        .sum     (sos_sum)
    );

    tals_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sos_done),
        .operand (sos_sum),
        .done    (root_done),
        .root    (step_len)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (sos_start) state_next = ST_SQUARE;
            ST_SQUARE: if (sos_done)  state_next = ST_ROOT;
            ST_ROOT:   if (root_done) state_next = ST_COMMIT;
            ST_COMMIT: if (out_free)  state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // arc update: saturating add, then threshold compare
    always_comb begin
        arc_sum   = {1'b0, arc_reg} + {{(ARC_W+1-ROOT_W){1'b0}}, step_len};
        arc_sat   = arc_sum[ARC_W] ? ARC_MAX : arc_sum[ARC_W-1:0];
        count_inc = (count_reg != INDEX_LIMIT) ? count_reg + 1'b1 : count_reg;
        hit       = (arc_sat >= seg_len_reg);
        leftover  = last_reg && (arc_sat != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            arc_reg       <= '0;
            count_reg     <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // a new segment replaces one that leaves in the same cycle
            if (commit && (hit || leftover)) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire) begin
                // a final point clears the stored point along with the rest
                prev_x_reg <= s_tlast ? '0 : pt_x;
                prev_y_reg <= s_tlast ? '0 : pt_y;
                prev_z_reg <= s_tlast ? '0 : pt_z;
                if (!have_prev_reg) begin
                    // first point of a trajectory carries no length
                    have_prev_reg <= !s_tlast;
                    count_reg     <= '0;
                    arc_reg       <= '0;
                end
            end
            if (commit) begin
                if (last_reg) begin
                    have_prev_reg <= 1'b0;
                    arc_reg       <= '0;
                    count_reg     <= '0;
                end else begin
                    arc_reg   <= hit ? '0 : arc_sat;
                    count_reg <= count_inc;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            last_reg <= s_tlast;
        end
        if (commit && (hit || leftover)) begin
            out_index_reg <= count_inc;
            out_arc_reg   <= arc_sat;
            out_final_reg <= !hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_arc_reg, out_index_reg};
    assign m_tuser  = out_final_reg;

endmodule

/* rtl/tals_sos.sv */
// bit-serial sum of three squares, one multiplier bit per cycle, msb first
module tals_sos import tals_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  mag_t             dx,
    input  mag_t             dy,
    input  mag_t             dz,
    output logic             done,
    output logic [SOS_W-1:0] sum
);

    mag_t                  mcx_reg, mcy_reg, mcz_reg;
    mag_t                  mpx_reg, mpy_reg, mpz_reg;
    logic [SOS_W-1:0]      acc_reg, acc_next;
    logic [SQ_CNT_W-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // shift the partial sum up and add the selected multiplicands
    always_comb begin
        acc_next = {acc_reg[SOS_W-2:0], 1'b0}
                 + (mpx_reg[COORD_W-1] ? {{(SOS_W-COORD_W){1'b0}}, mcx_reg} : '0)
                 + (mpy_reg[COORD_W-1] ? {{(SOS_W-COORD_W){1'b0}}, mcy_reg} : '0)
                 + (mpz_reg[COORD_W-1] ? {{(SOS_W-COORD_W){1'b0}}, mcz_reg} : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(COORD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcx_reg <= dx;
            mcy_reg <= dy;
            mcz_reg <= dz;
            mpx_reg <= dx;
            mpy_reg <= dy;
            mpz_reg <= dz;
            acc_reg <= '0;
        end else if (busy_reg) begin
            mpx_reg <= {mpx_reg[COORD_W-2:0], 1'b0};
            mpy_reg <= {mpy_reg[COORD_W-2:0], 1'b0};
            mpz_reg <= {mpz_reg[COORD_W-2:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

/* rtl/tals_sqrt.sv */
// bit-serial restoring floor square root, one root bit per cycle
module tals_sqrt import tals_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SOS_W-1:0]  operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [SOS_W-1:0]      op_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      diff;
    logic                  take;

    always_comb begin
        rem_sh = {rem_reg, op_reg[SOS_W-1:SOS_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= ROOT_CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ROOT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            op_reg   <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            op_reg <= {op_reg[SOS_W-3:0], 2'b00};
            if (take) begin
                rem_reg  <= diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
